// ----- rtl/smsrch_pkg.sv -----
package smsrch_pkg;

  // Fixed field widths of the channels and the configuration port
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 16;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Operation codes of an input item
  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'd1;

  // Reset value of both size registers
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  // Search sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_ISSUE,
    S_ROW_CMP,
    S_FIX_CMP,
    S_COL_ISSUE,
    S_COL_CMP,
    S_FIN_CMP
  } state_t;

endpackage

// ----- rtl/smsrch_in_if.sv -----
interface smsrch_in_if;
  import smsrch_pkg::*;

  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, row_index, col_index, value, input ready);
  modport sink   (input valid, operation, row_index, col_index, value, output ready);

endinterface

// ----- rtl/smsrch_out_if.sv -----
interface smsrch_out_if;
  import smsrch_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] hit_row;
  logic [IDX_W-1:0] hit_col;

  modport source (output valid, found, hit_row, hit_col, input ready);
  modport sink   (input valid, found, hit_row, hit_col, output ready);

endinterface

// ----- rtl/sorted_matrix_search.sv -----
// Sorted matrix search. A write item (operation 0) stores one signed element
// at row_index/col_index; indexes beyond the store are dropped. A search
// item (operation 1) runs a binary search down the first column for the last
// row whose first element is not above the target, then a binary search along
// that row for the first element not below it, and returns one result: found,
// the row and the column checked last. Every probe goes through the single
// read port of the element store, whose read data is registered, so each
// bisection step has an issue state and a compare state. The input is not
// ready while a search is in progress. Counts of zero are taken as one, counts
// above the store size as the store size. Contents must be loaded before they
// are searched.
module sorted_matrix_search #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  smsrch_in_if.sink                      in_ch,
  smsrch_out_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [smsrch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smsrch_pkg::CNT_W-1:0]   cfg_data
);
  import smsrch_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW    = (RW > CLW) ? RW : CLW;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EXT_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int LIM_W = 11;

  localparam logic [LIM_W-1:0] MAXR_L = LIM_W'(MAX_ROWS);
  localparam logic [LIM_W-1:0] MAXC_L = LIM_W'(MAX_COLS);
  localparam logic [AW-1:0]    COLS_A = AW'(MAX_COLS);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] rows_r, cols_r;
  logic [SW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic signed [DATA_WIDTH-1:0] target_r, target_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [IDX_W-1:0] out_row_r, out_row_nxt;
  logic [IDX_W-1:0] out_col_r, out_col_nxt;

  logic                         in_xfer;
  logic [EXT_W-1:0]             value_ext;
  logic [DATA_WIDTH-1:0]        value_dw;
  logic [LIM_W-1:0]             rows_ext, cols_ext, rows_eff, cols_eff;
  logic [SW-1:0]                last_row, last_col;
  logic [SW:0]                  mid_sum;
  logic [SW-1:0]                mid;
  logic                         lo_lt_hi;
  logic                         out_free;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [RW-1:0]                rd_row;
  logic [CLW-1:0]               rd_col;
  logic [AW-1:0]                rd_addr;
  logic [DATA_WIDTH-1:0]        rd_data;

  logic                         cmp_lt, cmp_eq;

  // Element store
  smsrch_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (value_dw),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Input handshake and value narrowing to the store width
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign value_ext   = EXT_W'($unsigned(in_ch.value));
  assign value_dw    = value_ext[DATA_WIDTH-1:0];

  // Write path: drop indexes outside the store
  assign wr_en = in_xfer && (in_ch.operation == OP_WRITE)
                 && (LIM_W'(in_ch.row_index) < MAXR_L)
                 && (LIM_W'(in_ch.col_index) < MAXC_L);
  assign wr_addr = AW'(RW'(in_ch.row_index)) * COLS_A + AW'(CLW'(in_ch.col_index));

  // Clamp counts to one..store size and take the last index
  assign rows_ext = LIM_W'(rows_r);
  assign cols_ext = LIM_W'(cols_r);
  assign rows_eff = (rows_ext == '0) ? LIM_W'(1) : ((rows_ext > MAXR_L) ? MAXR_L : rows_ext);
  assign cols_eff = (cols_ext == '0) ? LIM_W'(1) : ((cols_ext > MAXC_L) ? MAXC_L : cols_ext);
  assign last_row = SW'(rows_eff - LIM_W'(1));
  assign last_col = SW'(cols_eff - LIM_W'(1));

  // Bisection midpoint
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[SW:1];
  assign lo_lt_hi = (lo_r < hi_r);

  // Shared signed comparator against the element just read
  assign cmp_lt = (target_r < $signed(rd_data));
  assign cmp_eq = (target_r == $signed(rd_data));

  assign out_free = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_ch.operation == OP_SEARCH)) begin
          state_nxt = S_ROW_ISSUE;
        end
      end
      S_ROW_ISSUE: begin
        state_nxt = lo_lt_hi ? S_ROW_CMP : S_FIX_CMP;
      end
      S_ROW_CMP: begin
        state_nxt = S_ROW_ISSUE;
      end
      S_FIX_CMP: begin
        state_nxt = S_COL_ISSUE;
      end
      S_COL_ISSUE: begin
        state_nxt = lo_lt_hi ? S_COL_CMP : S_FIN_CMP;
      end
      S_COL_CMP: begin
        state_nxt = S_COL_ISSUE;
      end
      S_FIN_CMP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates and read address
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    row_nxt       = row_r;
    target_nxt    = target_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    rd_row        = row_r;
    rd_col        = CLW'(hi_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_ch.operation == OP_SEARCH)) begin
          target_nxt = $signed(value_dw);
          lo_nxt     = '0;
          hi_nxt     = last_row;
        end
      end
      S_ROW_ISSUE: begin
        rd_row = lo_lt_hi ? RW'(mid) : RW'(hi_r);
        rd_col = '0;
      end
      S_ROW_CMP: begin
        if (!cmp_lt) begin
          lo_nxt = mid + SW'(1);
        end else begin
          hi_nxt = mid;
        end
      end
      S_FIX_CMP: begin
        // step back one row when the probed row starts above the target
        if ((hi_r != '0) && cmp_lt) begin
          row_nxt = RW'(hi_r - SW'(1));
        end else begin
          row_nxt = RW'(hi_r);
        end
        lo_nxt = '0;
        hi_nxt = last_col;
      end
      S_COL_ISSUE: begin
        rd_col = lo_lt_hi ? CLW'(mid) : CLW'(hi_r);
      end
      S_COL_CMP: begin
        if (!cmp_lt && !cmp_eq) begin
          lo_nxt = mid + SW'(1);
        end else begin
          hi_nxt = mid;
        end
      end
      S_FIN_CMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = cmp_eq;
          out_row_nxt   = IDX_W'(row_r);
          out_col_nxt   = IDX_W'(hi_r);
        end
      end
      default: ;
    endcase
  end

  assign rd_addr = AW'(rd_row) * COLS_A + AW'(rd_col);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rows_r      <= CNT_RESET;
      cols_r      <= CNT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS_IN_USE: rows_r <= cfg_data;
          CFG_COLS_IN_USE: cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    row_r       <= row_nxt;
    target_r    <= target_nxt;
    out_found_r <= out_found_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.found   = out_found_r;
  assign out_ch.hit_row = out_row_r;
  assign out_ch.hit_col = out_col_r;

endmodule

// ----- rtl/smsrch_store.sv -----
module smsrch_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/smsrch_chk.sv -----
module smsrch_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_operation,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_found,
  input logic [smsrch_pkg::IDX_W-1:0] out_hit_row,
  input logic [smsrch_pkg::IDX_W-1:0] out_hit_col
);
  import smsrch_pkg::*;

  // A waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_hit_row) && $stable(out_hit_col))
    else $error("result changed while stalled");

  // A search keeps the input closed on the following cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_SEARCH) |=> !in_ready)
    else $error("input open right after a search transfer");

  // A new result only appears at the end of a search
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a search in progress");

  // A write gives no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_WRITE) && !out_valid |=> !out_valid)
    else $error("write produced a result");

endmodule

bind sorted_matrix_search smsrch_chk u_smsrch_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_hit_row  (out_ch.hit_row),
  .out_hit_col  (out_ch.hit_col)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import smsrch_pkg::*;

  localparam int STORE_DIM    = 64;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 350;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] hit_row;
    logic [IDX_W-1:0] hit_col;
  } search_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  smsrch_in_if  in_ch ();
  smsrch_out_if out_ch ();

  sorted_matrix_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the element store and the size registers
  logic signed [VAL_W-1:0] shadow_store [STORE_DIM][STORE_DIM];
  bit                      written      [STORE_DIM][STORE_DIM];
  logic [CNT_W-1:0]        shadow_rows;
  logic [CNT_W-1:0]        shadow_cols;

  search_result_t awaited_results [$];
  int             mismatch_count = 0;
  int             item_count     = 0;
  int             cycle_count    = 0;
  int             stall_left     = 0;
  bit             gaps_on        = 1'b0;

  // Free-running clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sorted_matrix_search");
      $finish;
    end
  end

  // Hold off the result side in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic int count_in_use(input logic [CNT_W-1:0] n);
    if (n == 0) return 1;
    if (n > STORE_DIM) return STORE_DIM;
    return n;
  endfunction

  // Two bisections: last row not above the target, then first column not below it
  function automatic search_result_t predict_search(input logic signed [VAL_W-1:0] target);
    int             n_rows;
    int             n_cols;
    int             lo;
    int             hi;
    int             mid;
    int             row;
    search_result_t res;
    n_rows = count_in_use(shadow_rows);
    n_cols = count_in_use(shadow_cols);
    lo = 0;
    hi = n_rows - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (target >= shadow_store[mid][0]) lo = mid + 1;
      else hi = mid;
    end
    row = hi;
    if (row > 0 && target < shadow_store[row][0]) row--;
    lo = 0;
    hi = n_cols - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (target > shadow_store[row][mid]) lo = mid + 1;
      else hi = mid;
    end
    res.found   = (shadow_store[row][hi] == target);
    res.hit_row = row[IDX_W-1:0];
    res.hit_col = hi[IDX_W-1:0];
    return res;
  endfunction

  // Compare each result transfer with the oldest outstanding search
  always @(negedge clk) begin
    search_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no search outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.found !== want.found)
          report_mismatch($sformatf("found %0b, expected %0b", out_ch.found, want.found));
        if (out_ch.hit_row !== want.hit_row)
          report_mismatch($sformatf("hit_row %0d, expected %0d", out_ch.hit_row, want.hit_row));
        if (out_ch.hit_col !== want.hit_col)
          report_mismatch($sformatf("hit_col %0d, expected %0d", out_ch.hit_col, want.hit_col));
      end
    end
  end

  // Present one item, wait for its transfer and update the shadow state
  task automatic send_item(input op_t op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [VAL_W-1:0] val);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.row_index <= row;
    in_ch.col_index <= col;
    in_ch.value     <= val;
    @(negedge clk);
    while (in_ch.ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    item_count++;
    if (op == OP_WRITE) begin
      shadow_store[row][col] = val;
      written[row][col]      = 1'b1;
    end else begin
      awaited_results.push_back(predict_search(val));
    end
  endtask

  // Drop valid, drain outstanding results and let a final write finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROWS_IN_USE) shadow_rows = val;
    else shadow_cols = val;
  endtask

  task automatic set_sizes(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols);
    settle();
    write_reg(CFG_ROWS_IN_USE, rows);
    write_reg(CFG_COLS_IN_USE, cols);
  endtask

  // Load the top-left block with a non-decreasing sequence of random steps
  task automatic fill_sorted(input int n_rows, input int n_cols);
    int total;
    int step_max;
    int level;
    total    = n_rows * n_cols;
    step_max = (total > 1) ? 65535 / (total - 1) : 65535;
    if (step_max > 40 && $urandom_range(0, 1) == 0) step_max = 40;
    level = -32768 + int'($urandom_range(0, 65535 - step_max * (total - 1)));
    for (int r = 0; r < n_rows; r++) begin
      for (int c = 0; c < n_cols; c++) begin
        if (r != 0 || c != 0)
          level += (c == 0) ? int'($urandom_range(1, step_max))
                            : int'($urandom_range(0, step_max));
        send_item(OP_WRITE, r[IDX_W-1:0], c[IDX_W-1:0], level[VAL_W-1:0]);
      end
    end
  endtask

  // Mostly members and near misses, some row starts, extremes and noise
  function automatic logic signed [VAL_W-1:0] pick_target(input int n_rows, input int n_cols);
    logic signed [VAL_W-1:0] member;
    member = shadow_store[$urandom_range(0, n_rows - 1)][$urandom_range(0, n_cols - 1)];
    case ($urandom_range(0, 7))
      0, 1, 2: return member;
      3:       return VAL_W'(member + 1);
      4:       return VAL_W'(member - 1);
      5:       return shadow_store[$urandom_range(0, n_rows - 1)][0];
      6:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_search(input logic signed [VAL_W-1:0] target);
    send_item(OP_SEARCH, IDX_W'($urandom_range(0, 63)), IDX_W'($urandom_range(0, 63)), target);
  endtask

  // Zero sizes fall back to a single cell; extremes of the value range
  task automatic test_single_cell();
    set_sizes(0, 0);
    send_item(OP_WRITE, 0, 0, 16'sh8000);
    send_item(OP_SEARCH, 63, 63, 16'sh8000);
    send_item(OP_SEARCH, 0, 0, 16'sh7FFF);
    send_item(OP_WRITE, 0, 0, 16'sh7FFF);
    send_item(OP_SEARCH, 0, 63, 16'sh7FFF);
    send_item(OP_SEARCH, 63, 0, 16'sh0000);
  endtask

  // Hand-built grid: row boundaries, gaps, duplicates and both ends
  task automatic test_small_grid();
    logic signed [VAL_W-1:0] grid [12] = '{16'sh8000, -100, -100, 5, 6, 20, 21, 40,
                                           41, 1000, 30000, 16'sh7FFF};
    logic signed [VAL_W-1:0] probes [8] = '{16'sh8000, 16'sh7FFF, 5, 6, -99, 40, 29999, -100};
    set_sizes(3, 4);
    for (int i = 0; i < 12; i++) send_item(OP_WRITE, IDX_W'(i / 4), IDX_W'(i % 4), grid[i]);
    foreach (probes[i]) send_search(probes[i]);
  endtask

  // Tall and wide blocks at the store limits; sizes above the store saturate
  task automatic test_full_store();
    set_sizes(127, 2);
    fill_sorted(STORE_DIM, 2);
    repeat (24) send_search(pick_target(STORE_DIM, 2));
    set_sizes(1, 127);
    fill_sorted(1, STORE_DIM);
    repeat (16) send_search(pick_target(1, STORE_DIM));
  endtask

  function automatic logic [CNT_W-1:0] extreme_size();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return 64;
      default: return 127;
    endcase
  endfunction

  // True when every entry of the top-left block holds a loaded value
  function automatic bit block_written(input int n_rows, input int n_cols);
    for (int r = 0; r < n_rows; r++) begin
      for (int c = 0; c < n_cols; c++) begin
        if (!written[r][c]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Phases of random sizes, mostly freshly sorted, some stale or corrupted
  task automatic test_random_mix();
    int               first_item;
    int               n_rows;
    int               n_cols;
    bit               reload;
    logic [CNT_W-1:0] rows_req;
    logic [CNT_W-1:0] cols_req;
    first_item = item_count;
    while (item_count - first_item < RANDOM_ITEMS) begin
      reload = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          rows_req = CNT_W'($urandom_range(1, 8));
          cols_req = CNT_W'($urandom_range(1, 8));
        end
        6: begin
          rows_req = CNT_W'($urandom_range(9, 64));
          cols_req = CNT_W'($urandom_range(1, 2));
        end
        7: begin
          rows_req = CNT_W'($urandom_range(1, 2));
          cols_req = CNT_W'($urandom_range(9, 64));
        end
        8: begin
          rows_req = extreme_size();
          cols_req = extreme_size();
          reload   = 1'b0;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            rows_req = CNT_W'($urandom_range(0, 127));
            cols_req = CNT_W'($urandom_range(0, 2));
          end else begin
            rows_req = CNT_W'($urandom_range(0, 2));
            cols_req = CNT_W'($urandom_range(0, 127));
          end
          reload = 1'b0;
        end
      endcase
      n_rows = count_in_use(rows_req);
      n_cols = count_in_use(cols_req);
      // Reuse stale contents only where every searched entry holds a value
      if (!reload && !block_written(n_rows, n_cols)) begin
        if (n_rows * n_cols > 2 * STORE_DIM) continue;
        reload = 1'b1;
      end
      set_sizes(rows_req, cols_req);
      gaps_on = (item_count - first_item < RANDOM_ITEMS * 4 / 5) && $urandom_range(0, 3) != 0;
      if (reload) fill_sorted(n_rows, n_cols);
      repeat ($urandom_range(10, 30)) begin
        if ($urandom_range(0, 9) == 0)
          send_item(OP_WRITE, IDX_W'($urandom_range(0, n_rows - 1)),
                    IDX_W'($urandom_range(0, n_cols - 1)), VAL_W'($urandom));
        else
          send_search(pick_target(n_rows, n_cols));
      end
    end
  endtask

  // Reset, then the tests in turn
  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_WRITE;
    in_ch.row_index <= '0;
    in_ch.col_index <= '0;
    in_ch.value     <= '0;
    shadow_rows = CNT_RESET;
    shadow_cols = CNT_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    gaps_on = 1'b1;
    test_single_cell();
    test_small_grid();
    test_full_store();
    test_random_mix();
    settle();
    if (mismatch_count == 0) begin
      $display("PASS sorted_matrix_search");
    end else begin
      $display("FAIL sorted_matrix_search");
    end
    $finish;
  end

endmodule
